FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: src/tesf_pkg.sv
package tesf_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned COUNT_BITS = 11;
  localparam int unsigned USED_BITS  = 11;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_SWAP  = 3'd2,
    OP_DUP   = 3'd3,
    OP_ALLOC = 3'd4,
    OP_FREE  = 3'd5,
    OP_PUT   = 3'd6,
    OP_TAKE  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_STACK_OVER  = 3'd1,
    ERR_STACK_UNDER = 3'd2,
    ERR_FRAME_OVER  = 3'd3,
    ERR_FRAME_UNDER = 3'd4
  } err_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: src/two_ended_stack_and_frame_core.sv
// Operand stack (growing up from entry 0) and frame area (growing down from the
// top) sharing one single-port-write word store. An item is taken when start_i
// is high and busy_o low; its result appears on the result ports for exactly one
// cycle with result_valid_o, and cannot be held off. Push, put, free, allocate of
// zero and every rejected item stay idle (busy_o low, result on the next cycle).
// Pop, take, dup pass S_LOAD or S_DUP (store read is registered); swap passes
// S_SWAP_A, S_SWAP_B, S_SWAP_C (two reads, two writes, one port). Frame
// allocate of count entries stays in S_FILL; the single write port fills one
// entry per cycle with nil_word. No clearing pass follows reset. The user must
// write nil_word via cfg_valid_i/cfg_data_i only while idle (not enforced).
module two_ended_stack_and_frame_core #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [2:0]                       operation_i,
  input  logic [tesf_pkg::VALUE_BITS-1:0]  value_i,
  input  logic [tesf_pkg::COUNT_BITS-1:0]  count_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tesf_pkg::VALUE_BITS-1:0]  cfg_data_i,
  output logic                             result_valid_o,
  output logic [tesf_pkg::VALUE_BITS-1:0]  result_word_o,
  output logic [2:0]                       error_code_o,
  output logic [tesf_pkg::USED_BITS-1:0]   stack_used_o,
  output logic [tesf_pkg::USED_BITS-1:0]   frame_used_o
);
  import tesf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (PW > USED_BITS) ? PW : USED_BITS;
  localparam int unsigned XW = 64;

  logic [WORD_BITS-1:0] nil_q;
  logic [XW-1:0]        value_x, cfg_x, res_x;
  logic [WORD_BITS-1:0] value_w, res_w, wr_data, rd_data;
  logic [AW-1:0]        wr_addr, rd_addr;
  mem_ctl_t             mem_ctl;
  err_e                 err;
  logic [PW-1:0]        stack_used, frame_used;
  logic [CW-1:0]        stack_ext, frame_ext;

  // words are stored at WORD_BITS; ports stay at 32 bits
  assign value_x = XW'(value_i);
  assign value_w = value_x[WORD_BITS-1:0];
  assign cfg_x   = XW'(cfg_data_i);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nil_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      nil_q <= cfg_x[WORD_BITS-1:0];
    end
  end

  tesf_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_e'(operation_i)),
    .value_i        (value_w),
    .count_i        (count_i),
    .nil_i          (nil_q),
    .mem_ctl_o      (mem_ctl),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .result_valid_o (result_valid_o),
    .result_word_o  (res_w),
    .error_code_o   (err),
    .stack_used_o   (stack_used),
    .frame_used_o   (frame_used)
  );

  tesf_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign res_x         = XW'(res_w);
  assign result_word_o = res_x[VALUE_BITS-1:0];
  assign error_code_o  = err;
  assign stack_ext     = CW'(stack_used);
  assign frame_ext     = CW'(frame_used);
  assign stack_used_o  = stack_ext[USED_BITS-1:0];
  assign frame_used_o  = frame_ext[USED_BITS-1:0];

endmodule

FILE: src/tesf_mem.sv
module tesf_mem #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                      clk_i,
  input  tesf_pkg::mem_ctl_t        ctl_i,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  logic [WORD_BITS-1:0]      wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr_i,
  output logic [WORD_BITS-1:0]      rd_data_o
);
  import tesf_pkg::*;

  logic [WORD_BITS-1:0] store_q [DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      store_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= store_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/tesf_ctrl.sv
`include "assert_macros.svh"

module tesf_ctrl #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  tesf_pkg::op_e                  op_i,
  input  logic [WORD_BITS-1:0]           value_i,
  input  logic [tesf_pkg::COUNT_BITS-1:0] count_i,
  input  logic [WORD_BITS-1:0]           nil_i,
  output tesf_pkg::mem_ctl_t             mem_ctl_o,
  output logic [$clog2(DEPTH)-1:0]       wr_addr_o,
  output logic [WORD_BITS-1:0]           wr_data_o,
  output logic [$clog2(DEPTH)-1:0]       rd_addr_o,
  input  logic [WORD_BITS-1:0]           rd_data_i,
  output logic                           result_valid_o,
  output logic [WORD_BITS-1:0]           result_word_o,
  output tesf_pkg::err_e                 error_code_o,
  output logic [$clog2(DEPTH+1)-1:0]     stack_used_o,
  output logic [$clog2(DEPTH+1)-1:0]     frame_used_o
);
  import tesf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (PW > COUNT_BITS) ? PW : COUNT_BITS;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOAD   = 7'b0000010,
    S_DUP    = 7'b0000100,
    S_SWAP_A = 7'b0001000,
    S_SWAP_B = 7'b0010000,
    S_SWAP_C = 7'b0100000,
    S_FILL   = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [PW-1:0]        stack_top_q, stack_top_d;
  logic [PW-1:0]        frame_base_q, frame_base_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [PW-1:0]        fill_cnt_q, fill_cnt_d;
  logic [WORD_BITS-1:0] tmp_q, tmp_d;
  logic [WORD_BITS-1:0] res_q, res_d;
  err_e                 err_q, err_d;
  logic                 valid_q, valid_d;

  logic [PW-1:0] free_space, frame_used, top_m1, top_m2, base_m1, new_base, cnt_p;
  logic [CW-1:0] cnt_ext, free_ext, used_ext;

  assign free_space = frame_base_q - stack_top_q;
  assign frame_used = PW'(DEPTH) - frame_base_q;
  assign top_m1     = stack_top_q - PW'(1);
  assign top_m2     = stack_top_q - PW'(2);
  assign base_m1    = frame_base_q - PW'(1);
  assign cnt_ext    = CW'(count_i);
  assign free_ext   = CW'(free_space);
  assign used_ext   = CW'(frame_used);
  // only used once the count is known to fit, so truncation is safe
  assign cnt_p      = cnt_ext[PW-1:0];
  assign new_base   = frame_base_q - cnt_p;

  always_comb begin
    state_d      = state_q;
    stack_top_d  = stack_top_q;
    frame_base_d = frame_base_q;
    addr_d       = addr_q;
    fill_cnt_d   = fill_cnt_q;
    tmp_d        = tmp_q;
    res_d        = res_q;
    err_d        = err_q;
    valid_d      = 1'b0;
    mem_ctl_o    = '0;
    wr_addr_o    = '0;
    wr_data_o    = '0;
    rd_addr_o    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d = '0;
          err_d = ERR_OK;
          unique case (op_i)
            OP_PUSH: begin
              valid_d = 1'b1;
              if (free_space == '0) begin
                err_d = ERR_STACK_OVER;
              end else begin
                mem_ctl_o.wr_en = 1'b1;
                wr_addr_o       = stack_top_q[AW-1:0];
                wr_data_o       = value_i;
                stack_top_d     = stack_top_q + PW'(1);
              end
            end
            OP_POP: begin
              if (stack_top_q == '0) begin
                err_d   = ERR_STACK_UNDER;
                valid_d = 1'b1;
              end else begin
                mem_ctl_o.rd_en = 1'b1;
                rd_addr_o       = top_m1[AW-1:0];
                stack_top_d     = top_m1;
                state_d         = S_LOAD;
              end
            end
            OP_SWAP: begin
              if (stack_top_q < PW'(2)) begin
                err_d   = ERR_STACK_UNDER;
                valid_d = 1'b1;
              end else begin
                mem_ctl_o.rd_en = 1'b1;
                rd_addr_o       = top_m1[AW-1:0];
                addr_d          = top_m2[AW-1:0];
                state_d         = S_SWAP_A;
              end
            end
            OP_DUP: begin
              if (stack_top_q == '0) begin
                err_d   = ERR_STACK_UNDER;
                valid_d = 1'b1;
              end else if (free_space == '0) begin
                err_d   = ERR_STACK_OVER;
                valid_d = 1'b1;
              end else begin
                mem_ctl_o.rd_en = 1'b1;
                rd_addr_o       = top_m1[AW-1:0];
                addr_d          = stack_top_q[AW-1:0];
                stack_top_d     = stack_top_q + PW'(1);
                state_d         = S_DUP;
              end
            end
            OP_ALLOC: begin
              if (cnt_ext > free_ext) begin
                err_d   = ERR_FRAME_OVER;
                valid_d = 1'b1;
              end else if (cnt_ext == '0) begin
                valid_d = 1'b1;
              end else begin
                frame_base_d = new_base;
                addr_d       = new_base[AW-1:0];
                fill_cnt_d   = cnt_p;
                state_d      = S_FILL;
              end
            end
            OP_FREE: begin
              valid_d = 1'b1;
              if (cnt_ext > used_ext) begin
                err_d = ERR_FRAME_UNDER;
              end else begin
                frame_base_d = frame_base_q + cnt_p;
              end
            end
            OP_PUT: begin
              valid_d = 1'b1;
              if (free_space == '0) begin
                err_d = ERR_FRAME_OVER;
              end else begin
                mem_ctl_o.wr_en = 1'b1;
                wr_addr_o       = base_m1[AW-1:0];
                wr_data_o       = value_i;
                frame_base_d    = base_m1;
              end
            end
            OP_TAKE: begin
              if (frame_used == '0) begin
                err_d   = ERR_FRAME_UNDER;
                valid_d = 1'b1;
              end else begin
                mem_ctl_o.rd_en = 1'b1;
                rd_addr_o       = frame_base_q[AW-1:0];
                frame_base_d    = frame_base_q + PW'(1);
                state_d         = S_LOAD;
              end
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      S_LOAD: begin
        res_d   = rd_data_i;
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_DUP: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o       = addr_q;
        wr_data_o       = rd_data_i;
        valid_d         = 1'b1;
        state_d         = S_IDLE;
      end
      S_SWAP_A: begin
        // upper word in hand, fetch the lower one
        tmp_d           = rd_data_i;
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = addr_q;
        state_d         = S_SWAP_B;
      end
      S_SWAP_B: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o       = addr_q + AW'(1);
        wr_data_o       = rd_data_i;
        state_d         = S_SWAP_C;
      end
      S_SWAP_C: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o       = addr_q;
        wr_data_o       = tmp_q;
        valid_d         = 1'b1;
        state_d         = S_IDLE;
      end
      S_FILL: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o       = addr_q;
        wr_data_o       = nil_i;
        addr_d          = addr_q + AW'(1);
        fill_cnt_d      = fill_cnt_q - PW'(1);
        if (fill_cnt_q == PW'(1)) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      stack_top_q  <= '0;
      frame_base_q <= PW'(DEPTH);
      valid_q      <= 1'b0;
      fill_cnt_q   <= '0;
    end else begin
      state_q      <= state_d;
      stack_top_q  <= stack_top_d;
      frame_base_q <= frame_base_d;
      valid_q      <= valid_d;
      fill_cnt_q   <= fill_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    tmp_q  <= tmp_d;
    res_q  <= res_d;
    err_q  <= err_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign result_word_o  = res_q;
  assign error_code_o   = err_q;
  assign stack_used_o   = stack_top_q;
  assign frame_used_o   = frame_used;

  `ASSERT_ALWAYS(a_areas_ordered, clk_i, rst_ni, stack_top_q <= frame_base_q, "stack overlaps frame")
  `ASSERT_ALWAYS(a_base_in_range, clk_i, rst_ni, frame_base_q <= PW'(DEPTH), "frame base beyond store")
  `ASSERT_IMPLY(a_strobe_idle, clk_i, rst_ni, valid_q, state_q == S_IDLE, "result while busy")
  `ASSERT_IMPLY(a_reject_no_change, clk_i, rst_ni, valid_q && (err_q != ERR_OK), $stable(stack_top_q) && $stable(frame_base_q), "rejected item moved a pointer")
  `ASSERT_IMPLY(a_fill_nonzero, clk_i, rst_ni, state_q == S_FILL, fill_cnt_q != '0, "fill with no entries left")

endmodule
